FILE: design/ues_pkg.sv
// Types, constants and helper functions for the unicycle Euler step block.
`default_nettype none
package ues_pkg;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] heading;
        logic signed [31:0] speed;
        logic signed [31:0] accel_cmd;
        logic signed [31:0] turn_cmd;
    } t_in;

    typedef struct packed {
        logic signed [31:0] next_x;
        logic signed [31:0] next_y;
        logic signed [31:0] next_heading;
        logic signed [31:0] next_speed;
        logic signed [31:0] jac_x_heading;
        logic signed [31:0] jac_x_speed;
        logic signed [31:0] jac_y_heading;
        logic signed [31:0] jac_y_speed;
        logic signed [31:0] clamped_accel;
        logic signed [31:0] clamped_turn;
    } t_out;

    // words carried alongside the angle path
    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] v;
        logic signed [31:0] nh;
        logic signed [31:0] ns;
        logic signed [31:0] ca;
        logic signed [31:0] ct;
    } t_side;

    localparam logic [2:0] REG_TIME_STEP = 3'd0;
    localparam logic [2:0] REG_ACCEL_MIN = 3'd1;
    localparam logic [2:0] REG_ACCEL_MAX = 3'd2;
    localparam logic [2:0] REG_TURN_MIN  = 3'd3;
    localparam logic [2:0] REG_TURN_MAX  = 3'd4;

    localparam logic [63:0] PI_Q60         = 64'h3243F6A8885A308D;
    localparam logic signed [47:0] PI_Q44      = 48'sh3243F6A8885A;
    localparam logic signed [47:0] TWO_PI_Q44  = 48'sh6487ED5110B4;
    localparam logic signed [47:0] HALF_PI_Q44 = 48'sh1921FB54442D;
    localparam logic signed [33:0] GAIN_Q30    = 34'sh26DD3B6A;
    // 2^14 turns, makes any scaled heading positive
    localparam logic signed [63:0] RED_OFS = 64'sh1921FB54442D0000;
    localparam int RED_STEPS = 16;

    function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
        logic [63:0] q;
        logic [63:0] r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[62:0], n[b]};
            if (r >= d) begin
                r = r - d;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // atan(2^-i) in Q44 from a truncated Q60 series; i = 0 uses pi/4 from PI_Q60
    function automatic logic [47:0] atan_q44(input int i);
        logic [63:0] sum;
        logic [63:0] term;
        int e;
        sum = '0;
        if (i == 0) begin
            return 48'((PI_Q60 >> 2) >> 16);
        end
        for (int k = 0; k < 61; k++) begin
            e = i * (2 * k + 1);
            if (e <= 60) begin
                term = udiv64(64'd1 << (60 - e), 64'(2 * k + 1));
                if (k % 2 == 1) begin
                    sum = sum - term;
                end else begin
                    sum = sum + term;
                end
            end
        end
        return 48'(sum >> 16);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end else if (v < -66'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

endpackage
`default_nettype wire

FILE: design/unicycle_euler_step.sv
// Unicycle kinematic model, one Euler step with Jacobian and command clamp.
// Throughput: one word per cycle; o_busy stays low, the pipeline never stalls.
// Depth is set by 16 angle reduction steps and the CORDIC rotation stages.
// Reset clears the valid bits and loads the default configuration.
`default_nettype none
module unicycle_euler_step #(
    parameter int CORDIC_STAGES = 18
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    output logic               o_busy,
    input  wire ues_pkg::t_in  i_in,
    output logic               o_valid,
    output ues_pkg::t_out      o_result,
    input  wire logic          i_cfg_we,
    input  wire logic [2:0]    i_cfg_idx,
    input  wire logic [31:0]   i_cfg_data
);

    localparam int LAT = CORDIC_STAGES + 24;
    localparam int RS  = ues_pkg::RED_STEPS;

    logic [16:0]        r_dt;
    logic signed [31:0] r_amin, r_amax, r_tmin, r_tmax;
    logic [LAT-1:0]     r_vld;
    logic               accept;

    assign o_busy  = 1'b0;
    assign accept  = i_start && !o_busy;
    assign o_valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dt   <= 17'd6554;
            r_amin <= -32'sd131072;
            r_amax <= 32'sd131072;
            r_tmin <= -32'sd65536;
            r_tmax <= 32'sd65536;
            r_vld  <= '0;
        end else begin
            r_vld <= {r_vld[LAT-2:0], accept};
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    ues_pkg::REG_TIME_STEP: r_dt   <= i_cfg_data[16:0];
                    ues_pkg::REG_ACCEL_MIN: r_amin <= i_cfg_data;
                    ues_pkg::REG_ACCEL_MAX: r_amax <= i_cfg_data;
                    ues_pkg::REG_TURN_MIN:  r_tmin <= i_cfg_data;
                    ues_pkg::REG_TURN_MAX:  r_tmax <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    logic signed [17:0] dt_s;
    assign dt_s = $signed({1'b0, r_dt});

    // stage: input capture, command products, clamps
    logic signed [31:0] n_ca, n_ct;
    always_comb begin
        n_ca = (i_in.accel_cmd > r_amax) ? r_amax : i_in.accel_cmd;
        if (n_ca < r_amin) begin
            n_ca = r_amin;
        end
        n_ct = (i_in.turn_cmd > r_tmax) ? r_tmax : i_in.turn_cmd;
        if (n_ct < r_tmin) begin
            n_ct = r_tmin;
        end
    end

    logic signed [31:0] r_x, r_y, r_v, r_h, r_ca, r_ct;
    logic signed [49:0] r_pw, r_pa;
    always_ff @(posedge i_clk) begin
        r_x  <= i_in.pos_x;
        r_y  <= i_in.pos_y;
        r_v  <= i_in.speed;
        r_h  <= i_in.heading;
        r_ca <= n_ca;
        r_ct <= n_ct;
        r_pw <= i_in.turn_cmd * dt_s;
        r_pa <= i_in.accel_cmd * dt_s;
    end

    // stage: heading and speed update, angle offset
    logic [62:0]        r_u [0:RS];
    ues_pkg::t_side     r_sd [0:RS];
    logic signed [33:0] rw, ra;
    logic signed [63:0] hs;
    ues_pkg::t_side     n_sd;
    always_comb begin
        rw = 34'((r_pw + 50'sd32768) >>> 16);
        ra = 34'((r_pa + 50'sd32768) >>> 16);
        hs = 64'(r_h) * 64'sd268435456 + ues_pkg::RED_OFS;
        n_sd.x  = r_x;
        n_sd.y  = r_y;
        n_sd.v  = r_v;
        n_sd.nh = ues_pkg::sat32(66'(r_h) + 66'(rw));
        n_sd.ns = ues_pkg::sat32(66'(r_v) + 66'(ra));
        n_sd.ca = r_ca;
        n_sd.ct = r_ct;
    end
    always_ff @(posedge i_clk) begin
        r_u[0]  <= hs[62:0];
        r_sd[0] <= n_sd;
    end

    // restoring reduction modulo 2pi, one multiple per stage
    for (genvar j = 0; j < RS; j++) begin : g_red
        localparam logic [62:0] STEP = 63'(ues_pkg::TWO_PI_Q44) << (RS - 1 - j);
        always_ff @(posedge i_clk) begin
            r_u[j+1]  <= (r_u[j] >= STEP) ? r_u[j] - STEP : r_u[j];
            r_sd[j+1] <= r_sd[j];
        end
    end

    // wrap to (-pi, pi]
    logic signed [47:0] r_zw;
    ues_pkg::t_side     r_sdw;
    always_ff @(posedge i_clk) begin
        r_zw  <= ($signed(r_u[RS][47:0]) > ues_pkg::PI_Q44)
                 ? $signed(r_u[RS][47:0]) - ues_pkg::TWO_PI_Q44 : $signed(r_u[RS][47:0]);
        r_sdw <= r_sd[RS];
    end

    // fold into [-pi/2, pi/2] and CORDIC rotation
    logic signed [33:0] r_cx [0:CORDIC_STAGES];
    logic signed [33:0] r_cy [0:CORDIC_STAGES];
    logic signed [47:0] r_cz [0:CORDIC_STAGES];
    logic               r_cn [0:CORDIC_STAGES];
    ues_pkg::t_side     r_cs [0:CORDIC_STAGES];

    always_ff @(posedge i_clk) begin
        r_cx[0] <= ues_pkg::GAIN_Q30;
        r_cy[0] <= '0;
        r_cs[0] <= r_sdw;
        if (r_zw > ues_pkg::HALF_PI_Q44) begin
            r_cz[0] <= r_zw - ues_pkg::PI_Q44;
            r_cn[0] <= 1'b1;
        end else if (r_zw < -ues_pkg::HALF_PI_Q44) begin
            r_cz[0] <= r_zw + ues_pkg::PI_Q44;
            r_cn[0] <= 1'b1;
        end else begin
            r_cz[0] <= r_zw;
            r_cn[0] <= 1'b0;
        end
    end

    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
        localparam logic signed [47:0] ATAN = $signed(ues_pkg::atan_q44(i));
        always_ff @(posedge i_clk) begin
            if (r_cz[i] >= 0) begin
                r_cx[i+1] <= r_cx[i] - (r_cy[i] >>> i);
                r_cy[i+1] <= r_cy[i] + (r_cx[i] >>> i);
                r_cz[i+1] <= r_cz[i] - ATAN;
            end else begin
                r_cx[i+1] <= r_cx[i] + (r_cy[i] >>> i);
                r_cy[i+1] <= r_cy[i] - (r_cx[i] >>> i);
                r_cz[i+1] <= r_cz[i] + ATAN;
            end
            r_cn[i+1] <= r_cn[i];
            r_cs[i+1] <= r_cs[i];
        end
    end

    // cos*dt, sin*dt
    logic signed [33:0] c30, s30;
    logic signed [51:0] r_pc, r_ps;
    ues_pkg::t_side     r_sm1;
    assign c30 = r_cn[CORDIC_STAGES] ? -r_cx[CORDIC_STAGES] : r_cx[CORDIC_STAGES];
    assign s30 = r_cn[CORDIC_STAGES] ? -r_cy[CORDIC_STAGES] : r_cy[CORDIC_STAGES];
    always_ff @(posedge i_clk) begin
        r_pc  <= c30 * dt_s;
        r_ps  <= s30 * dt_s;
        r_sm1 <= r_cs[CORDIC_STAGES];
    end

    logic signed [33:0] r_cdt, r_sdt;
    ues_pkg::t_side     r_sr;
    always_ff @(posedge i_clk) begin
        r_cdt <= 34'((r_pc + 52'sd32768) >>> 16);
        r_sdt <= 34'((r_ps + 52'sd32768) >>> 16);
        r_sr  <= r_sm1;
    end

    // speed products and the dt-only Jacobian entries
    logic signed [65:0] r_pvc, r_pvs;
    logic signed [31:0] r_jxs, r_jys;
    ues_pkg::t_side     r_sm2;
    always_ff @(posedge i_clk) begin
        r_pvc <= 66'(r_sr.v) * 66'(r_cdt);
        r_pvs <= 66'(r_sr.v) * 66'(r_sdt);
        r_jxs <= ues_pkg::sat32(66'((r_cdt + 34'sd8192) >>> 14));
        r_jys <= ues_pkg::sat32(66'((r_sdt + 34'sd8192) >>> 14));
        r_sm2 <= r_sr;
    end

    logic signed [35:0] dx, dy;
    assign dx = 36'((r_pvc + 66'sd536870912) >>> 30);
    assign dy = 36'((r_pvs + 66'sd536870912) >>> 30);

    always_ff @(posedge i_clk) begin
        o_result.next_x        <= ues_pkg::sat32(66'(r_sm2.x) + 66'(dx));
        o_result.next_y        <= ues_pkg::sat32(66'(r_sm2.y) + 66'(dy));
        o_result.next_heading  <= r_sm2.nh;
        o_result.next_speed    <= r_sm2.ns;
        o_result.jac_x_heading <= ues_pkg::sat32(-66'(dy));
        o_result.jac_x_speed   <= r_jxs;
        o_result.jac_y_heading <= ues_pkg::sat32(66'(dx));
        o_result.jac_y_speed   <= r_jys;
        o_result.clamped_accel <= r_sm2.ca;
        o_result.clamped_turn  <= r_sm2.ct;
    end

    a_no_busy: assert property (@(posedge i_clk) !o_busy)
        else $error("busy raised");
    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("word after reset");
    a_valid_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_start, LAT))
        else $error("word without start");

endmodule
`default_nettype wire
